FILE: hw/rtl/sfg_pkg.sv
// ----------------------------------------------------------------------------
// sfg_pkg
// Shared types and constants for the stepped fan governor: word layouts,
// temperature conversion constants, step count and the duty table.
// ----------------------------------------------------------------------------
package sfg_pkg;

    // Number of fan steps including "off"; the highest step is NUM_STEPS-1,
    // capped by the five threshold registers that exist in hardware.
    localparam int NUM_STEPS = 6;
    localparam int HW_TOP_STEP = 5;
    localparam int TOP_STEP_RAW = (NUM_STEPS < 2) ? 1 : (NUM_STEPS - 1);
    localparam int TOP_STEP = (TOP_STEP_RAW > HW_TOP_STEP) ? HW_TOP_STEP : TOP_STEP_RAW;

    localparam int RAW_W   = 10;
    localparam int TEMP_W  = 20;
    localparam int HYST_W  = 16;
    localparam int STEP_W  = 3;
    localparam int DUTY_W  = 10;
    localparam int CMP_W   = TEMP_W + 2;

    localparam logic [TEMP_W-1:0] TEMP_OFFSET = 20'd450000;

    // Register indexes of the configuration port.
    localparam logic [2:0] REG_THR1 = 3'd0;
    localparam logic [2:0] REG_THR2 = 3'd1;
    localparam logic [2:0] REG_THR3 = 3'd2;
    localparam logic [2:0] REG_THR4 = 3'd3;
    localparam logic [2:0] REG_THR5 = 3'd4;
    localparam logic [2:0] REG_HYST = 3'd5;

    localparam logic [TEMP_W-1:0] THR1_RESET = 20'd45000;
    localparam logic [TEMP_W-1:0] THR2_RESET = 20'd52000;
    localparam logic [TEMP_W-1:0] THR3_RESET = 20'd58000;
    localparam logic [TEMP_W-1:0] THR4_RESET = 20'd64000;
    localparam logic [TEMP_W-1:0] THR5_RESET = 20'd70000;
    localparam logic [HYST_W-1:0] HYST_RESET = 16'd3000;

    typedef logic signed [TEMP_W-1:0] temp_t;

    // Threshold for step k+1 lives at element k.
    typedef logic [HW_TOP_STEP-1:0][TEMP_W-1:0] thr_vec_t;

    // Per-step comparison flags; bit k-1 belongs to step k.
    typedef struct packed {
        logic [HW_TOP_STEP-1:0] reach;  // temperature >= threshold of step k
        logic [HW_TOP_STEP-1:0] below;  // temperature < threshold of step k - hysteresis
    } cmp_flags_t;

    function automatic logic [DUTY_W-1:0] duty_of(input logic [STEP_W-1:0] step);
        logic [DUTY_W-1:0] duty;
        case (step)
            3'd1:    duty = 10'd400;
            3'd2:    duty = 10'd550;
            3'd3:    duty = 10'd700;
            3'd4:    duty = 10'd850;
            3'd5:    duty = 10'd1000;
            default: duty = 10'd0;
        endcase
        return duty;
    endfunction

endpackage

FILE: hw/rtl/sfg_eval.sv
// ----------------------------------------------------------------------------
// sfg_eval
// Converts a raw sensor code to millicelsius and compares the temperature
// against every step threshold, with and without hysteresis.
// ----------------------------------------------------------------------------
module sfg_eval (
    input  logic [sfg_pkg::RAW_W-1:0]  raw,
    input  sfg_pkg::thr_vec_t          thresholds,
    input  logic [sfg_pkg::HYST_W-1:0] hysteresis,
    output sfg_pkg::temp_t             temp,
    output sfg_pkg::cmp_flags_t        flags
);

    logic [sfg_pkg::TEMP_W-1:0]         product;
    logic signed [sfg_pkg::CMP_W-1:0]   temp_wide;
    logic signed [sfg_pkg::CMP_W-1:0]   thr_wide [sfg_pkg::HW_TOP_STEP];
    logic signed [sfg_pkg::CMP_W-1:0]   low_wide [sfg_pkg::HW_TOP_STEP];

    // 550 = 512 + 32 + 4 + 2, built from shifted copies of the code.
    assign product = {1'b0, raw, 9'b0} + {5'b0, raw, 5'b0}
                   + {8'b0, raw, 2'b0} + {9'b0, raw, 1'b0};

    assign temp_wide = $signed({2'b00, sfg_pkg::TEMP_OFFSET}) - $signed({2'b00, product});
    assign temp      = temp_wide[sfg_pkg::TEMP_W-1:0];

    always_comb
    begin
        for (int k = 0; k < sfg_pkg::HW_TOP_STEP; k++)
        begin
            thr_wide[k] = $signed({{2{thresholds[k][sfg_pkg::TEMP_W-1]}}, thresholds[k]});
            low_wide[k] = thr_wide[k] - $signed({6'b0, hysteresis});
            flags.reach[k] = (temp_wide >= thr_wide[k]);
            flags.below[k] = (temp_wide < low_wide[k]);
        end
    end

endmodule

FILE: hw/rtl/stepped_fan_governor_hysteresis.sv
// ----------------------------------------------------------------------------
// stepped_fan_governor_hysteresis
// Stepped fan curve with hysteresis on a stream of temperature readings.
// ----------------------------------------------------------------------------
// Data path: a reading accepted from the stream goes to the input register,
// then its result word to the result register that drives m_tdata.
// Throughput: one reading per cycle while m_tready stays high; the step
// update is combinational and the result register loads as the input
// register passes on, so back-to-back readings go through without a gap.
// Reset: rst_n clears the pipeline, sets the step to off, clears the first
// reading flag and loads the default thresholds and hysteresis.
// ----------------------------------------------------------------------------
module stepped_fan_governor_hysteresis (
    input  logic        clk,
    input  logic        rst_n,

    // Reading stream.
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [9:0] sensor_raw, rest zero
    input  logic [0:0]  s_tuser,   // [0] sensor_valid

    // Result stream.
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // [2:0] fan_step, [12:3] duty_permille,
                                   // [32:13] temp_millic, [33] step_changed, rest zero

    // Register write channel.
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [19:0] cfg_data
);

    // Configuration registers.
    sfg_pkg::thr_vec_t              thr_reg;
    logic [sfg_pkg::HYST_W-1:0]     hyst_reg;

    // Input register. Readings without the valid bit are taken and dropped here.
    logic                           in_valid_reg;
    logic [sfg_pkg::RAW_W-1:0]      in_raw_reg;

    // Governor state.
    logic [sfg_pkg::STEP_W-1:0]     step_reg;
    logic [sfg_pkg::STEP_W-1:0]     step_next;
    logic                           seen_reg;

    // Result register.
    logic                           out_valid_reg;
    logic [sfg_pkg::STEP_W-1:0]     out_step_reg;
    logic [sfg_pkg::DUTY_W-1:0]     out_duty_reg;
    sfg_pkg::temp_t                 out_temp_reg;
    logic                           out_changed_reg;

    sfg_pkg::temp_t                 temp;
    sfg_pkg::cmp_flags_t            flags;

    logic                           out_free;
    logic                           advance;
    logic                           in_take;

    // The result register can load when it is empty or being drained this
    // cycle; the input register then passes its reading on.
    assign out_free  = !out_valid_reg || m_tready;
    assign advance   = in_valid_reg && out_free;
    assign s_tready  = !in_valid_reg || out_free;
    assign in_take   = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    sfg_eval u_eval (
        .raw        (in_raw_reg),
        .thresholds (thr_reg),
        .hysteresis (hyst_reg),
        .temp       (temp),
        .flags      (flags)
    );

    // Step update: first climb while the next threshold is reached, then
    // fall while the temperature sits a full hysteresis below the current
    // step's threshold. Each pass is a short chain over at most five steps.
    always_comb
    begin
        step_next = step_reg;
        if (step_next > sfg_pkg::STEP_W'(sfg_pkg::TOP_STEP))
        begin
            step_next = sfg_pkg::STEP_W'(sfg_pkg::TOP_STEP);
        end
        for (int k = 1; k <= sfg_pkg::TOP_STEP; k++)
        begin
            if (step_next == sfg_pkg::STEP_W'(k - 1) && flags.reach[k-1])
            begin
                step_next = sfg_pkg::STEP_W'(k);
            end
        end
        for (int k = sfg_pkg::TOP_STEP; k >= 1; k--)
        begin
            if (step_next == sfg_pkg::STEP_W'(k) && flags.below[k-1])
            begin
                step_next = sfg_pkg::STEP_W'(k - 1);
            end
        end
    end

    // Configuration writes; indexes past the hysteresis register are ignored.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg[0] <= sfg_pkg::THR1_RESET;
            thr_reg[1] <= sfg_pkg::THR2_RESET;
            thr_reg[2] <= sfg_pkg::THR3_RESET;
            thr_reg[3] <= sfg_pkg::THR4_RESET;
            thr_reg[4] <= sfg_pkg::THR5_RESET;
            hyst_reg   <= sfg_pkg::HYST_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                sfg_pkg::REG_THR1: thr_reg[0] <= cfg_data;
                sfg_pkg::REG_THR2: thr_reg[1] <= cfg_data;
                sfg_pkg::REG_THR3: thr_reg[2] <= cfg_data;
                sfg_pkg::REG_THR4: thr_reg[3] <= cfg_data;
                sfg_pkg::REG_THR5: thr_reg[4] <= cfg_data;
                sfg_pkg::REG_HYST: hyst_reg   <= cfg_data[sfg_pkg::HYST_W-1:0];
                default:           ;
            endcase
        end
    end

    // Pipeline control and governor state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            step_reg      <= '0;
            seen_reg      <= 1'b0;
        end
        else
        begin
            if (in_take)
            begin
                in_valid_reg <= s_tuser[0];
            end
            else if (advance)
            begin
                in_valid_reg <= 1'b0;
            end

            if (advance)
            begin
                out_valid_reg <= 1'b1;
                step_reg      <= step_next;
                seen_reg      <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            in_raw_reg <= s_tdata[sfg_pkg::RAW_W-1:0];
        end
        if (advance)
        begin
            out_step_reg    <= step_next;
            out_duty_reg    <= sfg_pkg::duty_of(step_next);
            out_temp_reg    <= temp;
            out_changed_reg <= !seen_reg || (step_next != step_reg);
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {6'b0, out_changed_reg, out_temp_reg, out_duty_reg, out_step_reg};

endmodule
